[rtl/mtr_pkg.sv]
package mtr_pkg;

	localparam int unsigned DW  = 32;
	localparam int unsigned FB  = 24;
	localparam int unsigned CW  = 2 * DW + 1;
	localparam int unsigned PW  = 3 * DW + 4;
	localparam int unsigned QB  = DW + 1;
	localparam int unsigned NW  = PW + FB + 2;
	localparam int unsigned RW  = PW + 1;
	localparam int unsigned DRW = PW - 2 * FB + 1;
	localparam int unsigned NT  = 9;
	localparam int unsigned NS  = QB + 7;

	typedef logic signed [DW-1:0]   sdw_t;
	typedef logic signed [2*DW-1:0] prod_t;
	typedef logic signed [CW-1:0]   cof_t;
	typedef logic signed [2*DW:0]   pp_t;
	typedef logic signed [PW-1:0]   wide_t;

	// product operand pairs; cofactor k = prod[2k] - prod[2k+1]
	// metric index: xx=0 xy=1 xz=2 yy=3 yz=4 zz=5
	localparam logic [2:0] PA [12] = '{3'd3, 3'd4, 3'd2, 3'd1, 3'd1, 3'd2,
		3'd0, 3'd2, 3'd1, 3'd0, 3'd0, 3'd1};
	localparam logic [2:0] PB [12] = '{3'd5, 3'd4, 3'd4, 3'd5, 3'd4, 3'd3,
		3'd5, 3'd2, 3'd2, 3'd4, 3'd3, 3'd1};
	// cofactor order: xx, xy, xz, yy, yz, zz; cofactor used by each term
	localparam logic [2:0] TC [NT] = '{3'd0, 3'd1, 3'd2, 3'd0, 3'd3, 3'd5,
		3'd1, 3'd2, 3'd4};

	typedef struct packed {
		logic          neg;
		logic          ovf;
		logic          sing;
		logic          dclip;
		logic [DW-1:0] dval;
	} side_t;

	typedef struct packed {
		logic [RW-1:0] r;
		logic [RW-1:0] d;
		logic [QB-1:0] nlo;
		logic [QB-1:0] q;
		side_t         sd;
	} div_word_t;

endpackage

[rtl/mtr_front.sv]
module mtr_front import mtr_pkg::*; (
	input  logic             clk,
	input  logic [4:0]       en,
	input  logic [12*DW-1:0] in_data,
	output wide_t            det,
	output wide_t            num
);

	sdw_t  fld [12];
	prod_t prod_s1 [12];
	sdw_t  x_s1 [3];
	sdw_t  t_s1 [6];
	cof_t  cof_s2 [6];
	sdw_t  x_s2 [3];
	sdw_t  t_s2 [6];
	sdw_t  opx [NT];
	cof_t  opc [NT];
	pp_t   lo_s3 [NT];
	pp_t   hi_s3 [NT];
	wide_t term_s4 [NT];
	wide_t det_s5;
	wide_t num_s5;

	always_comb begin
		for (int k = 0; k < 12; k++) begin
			fld[k] = in_data[k*DW +: DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int k = 0; k < 12; k++) begin
				prod_s1[k] <= fld[{1'b0, PA[k]}] * fld[{1'b0, PB[k]}];
			end
			for (int k = 0; k < 3; k++) begin
				x_s1[k] <= fld[k];
			end
			for (int k = 0; k < 6; k++) begin
				t_s1[k] <= fld[6+k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int k = 0; k < 6; k++) begin
				cof_s2[k] <= CW'(prod_s1[2*k]) - CW'(prod_s1[2*k+1]);
			end
			x_s2 <= x_s1;
			t_s2 <= t_s1;
		end
	end

	// terms: det = a*cxx + b*cxy + c*cxz; diagonal, then off-diagonal tensor terms
	always_comb begin
		opx[0] = x_s2[0];
		opx[1] = x_s2[1];
		opx[2] = x_s2[2];
		opx[3] = t_s2[0];
		opx[4] = t_s2[3];
		opx[5] = t_s2[5];
		opx[6] = t_s2[1];
		opx[7] = t_s2[2];
		opx[8] = t_s2[4];
		for (int k = 0; k < NT; k++) begin
			opc[k] = cof_s2[TC[k]];
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int k = 0; k < NT; k++) begin
				lo_s3[k] <= opx[k] * $signed({1'b0, opc[k][DW-1:0]});
				hi_s3[k] <= opx[k] * $signed(opc[k][CW-1:DW]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int k = 0; k < NT; k++) begin
				term_s4[k] <= (PW'(hi_s3[k]) <<< DW) + PW'(lo_s3[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			num_s5 <= term_s4[3] + term_s4[4] + term_s4[5]
				+ ((term_s4[6] + term_s4[7] + term_s4[8]) <<< 1);
		end
	end

	assign det = det_s5;
	assign num = num_s5;

endmodule

[rtl/mtr_prep.sv]
module mtr_prep import mtr_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  wide_t     det,
	input  wide_t     num,
	output div_word_t word
);

	logic          dneg;
	logic          nneg;
	logic [PW-1:0] dmag;
	logic [PW-1:0] nmag;
	logic [PW:0]   dsum;
	logic [DRW-1:0] dr;
	logic [DRW-1:0] lim;
	logic [DRW-1:0] drn;
	logic [NW-1:0] np;
	logic [RW-1:0] dp;
	logic [RW-1:0] r0;
	div_word_t     nxt;
	div_word_t     word_s6;

	always_comb begin
		dneg = det[PW-1];
		nneg = num[PW-1];
		dmag = dneg ? PW'(-det) : PW'(det);
		nmag = nneg ? PW'(-num) : PW'(num);
		dsum = {1'b0, dmag} + ((PW+1)'(1) << (2*FB-1));
		dr   = dsum[PW:2*FB];
		lim  = DRW'(1) << (DW-1);
		drn  = -dr;
		np   = (NW'(nmag) << (FB+1)) + NW'(dmag);
		dp   = {dmag, 1'b0};
		r0   = RW'(np[NW-1:QB]);

		nxt.r        = r0;
		nxt.d        = dp;
		nxt.nlo      = np[QB-1:0];
		nxt.q        = '0;
		nxt.sd.neg   = nneg ^ dneg;
		nxt.sd.ovf   = r0 >= dp;
		nxt.sd.sing  = det == '0;
		if (dneg) begin
			nxt.sd.dclip = dr > lim;
			nxt.sd.dval  = (dr > lim) ? lim[DW-1:0] : drn[DW-1:0];
		end else begin
			nxt.sd.dclip = dr >= lim;
			nxt.sd.dval  = (dr >= lim) ? DW'(lim - DRW'(1)) : dr[DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s6 <= nxt;
		end
	end

	assign word = word_s6;

endmodule

[rtl/mtr_div_step.sv]
module mtr_div_step import mtr_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  div_word_t din,
	output div_word_t dout
);

	logic [RW:0] r2;
	logic [RW:0] diff;
	logic        ge;
	div_word_t   nxt;
	div_word_t   word_q;

	always_comb begin
		r2   = {din.r, din.nlo[QB-1]};
		diff = r2 - {1'b0, din.d};
		ge   = r2 >= {1'b0, din.d};
		nxt     = din;
		nxt.r   = ge ? diff[RW-1:0] : r2[RW-1:0];
		nxt.nlo = {din.nlo[QB-2:0], 1'b0};
		nxt.q   = {din.q[QB-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= nxt;
		end
	end

	assign dout = word_q;

endmodule

[rtl/mtr_post.sv]
module mtr_post import mtr_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  div_word_t     din,
	output logic [DW-1:0] trace_out,
	output logic [DW-1:0] determinant,
	output logic          singular,
	output logic          clipped
);

	logic [QB-1:0] lim;
	logic [QB-1:0] qn;
	logic [DW-1:0] tr;
	logic          tclip;
	logic [DW-1:0] trace_q;
	logic [DW-1:0] det_q;
	logic          sing_q;
	logic          clip_q;

	always_comb begin
		lim = QB'(1) << (DW-1);
		qn  = -din.q;
		if (din.sd.neg) begin
			tclip = din.sd.ovf || (din.q > lim);
			tr    = tclip ? lim[DW-1:0] : qn[DW-1:0];
		end else begin
			tclip = din.sd.ovf || (din.q >= lim);
			tr    = tclip ? DW'(lim - QB'(1)) : din.q[DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (din.sd.sing) begin
				trace_q <= '0;
				det_q   <= '0;
				sing_q  <= 1'b1;
				clip_q  <= 1'b0;
			end else begin
				trace_q <= tr;
				det_q   <= din.sd.dval;
				sing_q  <= 1'b0;
				clip_q  <= tclip | din.sd.dclip;
			end
		end
	end

	assign trace_out   = trace_q;
	assign determinant = det_q;
	assign singular    = sing_q;
	assign clipped     = clip_q;

endmodule

[rtl/metric_trace_sym3x3_top.sv]
// Each item passes the front, prep, divide and post stages between input accept and result valid.
// Throughput: one item per cycle while the output is not stalled; 33 restoring divide stages, one quotient bit each.
// Each stage holds its item until the next stage frees, so bubbles collapse.
// Reset (arst_n low) clears the stage valid bits only; no clearing pass.
module metric_trace_sym3x3_top import mtr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// metric_xx, metric_xy, metric_xz, metric_yy, metric_yz, metric_zz,
	// tens_xx, tens_xy, tens_xz, tens_yy, tens_yz, tens_zz
	input  logic [12*DW-1:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// trace_out, determinant
	output logic [2*DW-1:0]  m_axis_tdata,
	// singular, clipped
	output logic [1:0]       m_axis_tuser
);

	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;
	wide_t         det;
	wide_t         num;
	div_word_t     dw [QB+1];
	logic [DW-1:0] trace_out;
	logic [DW-1:0] determinant;
	logic          singular;
	logic          clipped;

	always_comb begin
		en[NS-1] = !vld_q[NS-1] || m_axis_tready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_axis_tvalid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	mtr_front u_front (
		.clk     (clk),
		.en      (en[4:0]),
		.in_data (s_axis_tdata),
		.det     (det),
		.num     (num)
	);

	mtr_prep u_prep (
		.clk  (clk),
		.en   (en[5]),
		.det  (det),
		.num  (num),
		.word (dw[0])
	);

	for (genvar j = 0; j < QB; j++) begin : g_div
		mtr_div_step u_step (
			.clk  (clk),
			.en   (en[6+j]),
			.din  (dw[j]),
			.dout (dw[j+1])
		);
	end

	mtr_post u_post (
		.clk         (clk),
		.en          (en[NS-1]),
		.din         (dw[QB]),
		.trace_out   (trace_out),
		.determinant (determinant),
		.singular    (singular),
		.clipped     (clipped)
	);

	assign s_axis_tready = en[0];
	assign m_axis_tvalid = vld_q[NS-1];
	assign m_axis_tdata  = {determinant, trace_out};
	assign m_axis_tuser  = {clipped, singular};

endmodule
